[rtl/core/awu_pkg.sv]
package awu_pkg;

   // Field and datapath widths.
   localparam int ADDR_W = 12;
   localparam int WORD_W = 32;
   localparam int LR_W = 16;
   localparam int EPS_W = 32;
   localparam int ACC_W = 64;
   localparam int ROOT_W = 32;
   localparam int NUM_W = 48;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   // Pipeline geometry: two root digits and two quotient bits per stage.
   localparam int SQRT_STAGES = ACC_W / 4;
   localparam int DIV_STAGES = NUM_W / 2;

   // Result queue.
   localparam int FIFO_DEPTH = 64;
   localparam int FIFO_PTR_W = 6;
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON = 1'b1;

   // Register reset values.
   localparam logic [LR_W-1:0] LR_RESET = 16'd655;
   localparam logic [EPS_W-1:0] EPS_RESET = 32'd43;

   typedef struct packed {
      logic [ADDR_W-1:0] param_address;
      logic signed [WORD_W-1:0] current_weight;
      logic signed [WORD_W-1:0] gradient;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] new_weight;
      logic [ADDR_W-1:0] out_address;
      logic saturated;
   } rsp_word_type;

   // What travels alongside an item through the root and divide pipes.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic signed [WORD_W-1:0] weight;
      logic neg;
      logic sat;
      logic p_nz;
   } side_type;

endpackage

[rtl/core/awu_sqrt_pipe.sv]
module awu_sqrt_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  logic [63:0]           in_x,
   input  logic [47:0]           in_p,
   input  awu_pkg::side_type     in_side,
   output logic                  out_vld,
   output logic [31:0]           out_root,
   output logic [47:0]           out_p,
   output awu_pkg::side_type     out_side
);
   import awu_pkg::*;

   logic            vld_ff  [SQRT_STAGES];
   logic [63:0]     x_ff    [SQRT_STAGES];
   logic [33:0]     rem_ff  [SQRT_STAGES];
   logic [31:0]     root_ff [SQRT_STAGES];
   logic [47:0]     p_ff    [SQRT_STAGES];
   side_type        side_ff [SQRT_STAGES];

   logic            vld_in  [SQRT_STAGES];
   logic [63:0]     x_in    [SQRT_STAGES];
   logic [33:0]     rem_in  [SQRT_STAGES];
   logic [31:0]     root_in [SQRT_STAGES];
   logic [47:0]     p_in    [SQRT_STAGES];
   side_type        side_in [SQRT_STAGES];

   // Each stage resolves two root bits from the next four radicand bits.
   always_comb begin
      logic [63:0] x;
      logic [33:0] rem;
      logic [31:0] root;
      logic [35:0] rem_sh;
      logic [35:0] trial;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            x = in_x;
            rem = '0;
            root = '0;
            vld_in[j] = in_vld;
            p_in[j] = in_p;
            side_in[j] = in_side;
         end else begin
            x = x_ff[j-1];
            rem = rem_ff[j-1];
            root = root_ff[j-1];
            vld_in[j] = vld_ff[j-1];
            p_in[j] = p_ff[j-1];
            side_in[j] = side_ff[j-1];
         end
         for (int k = 0; k < 2; k++) begin
            rem_sh = {rem, x[63:62]};
            trial = {2'b00, root, 2'b01};
            if (rem_sh >= trial) begin
               rem = 34'(rem_sh - trial);
               root = {root[30:0], 1'b1};
            end else begin
               rem = 34'(rem_sh);
               root = {root[30:0], 1'b0};
            end
            x = {x[61:0], 2'b00};
         end
         x_in[j] = x;
         rem_in[j] = rem;
         root_in[j] = root;
      end
   end

   // Stage registers; only the valid bits need a reset.
   always_ff @(posedge clock) begin
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_in[j];
         end
         x_ff[j] <= x_in[j];
         rem_ff[j] <= rem_in[j];
         root_ff[j] <= root_in[j];
         p_ff[j] <= p_in[j];
         side_ff[j] <= side_in[j];
      end
   end

   assign out_vld = vld_ff[SQRT_STAGES-1];
   assign out_root = root_ff[SQRT_STAGES-1];
   assign out_p = p_ff[SQRT_STAGES-1];
   assign out_side = side_ff[SQRT_STAGES-1];

endmodule

[rtl/core/awu_div_pipe.sv]
module awu_div_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  logic [47:0]           in_num,
   input  logic [31:0]           in_den,
   input  awu_pkg::side_type     in_side,
   output logic                  out_vld,
   output logic [47:0]           out_quo,
   output logic [31:0]           out_den,
   output awu_pkg::side_type     out_side
);
   import awu_pkg::*;

   logic            vld_ff  [DIV_STAGES];
   logic [47:0]     num_ff  [DIV_STAGES];
   logic [47:0]     quo_ff  [DIV_STAGES];
   logic [31:0]     rem_ff  [DIV_STAGES];
   logic [31:0]     den_ff  [DIV_STAGES];
   side_type        side_ff [DIV_STAGES];

   logic            vld_in  [DIV_STAGES];
   logic [47:0]     num_in  [DIV_STAGES];
   logic [47:0]     quo_in  [DIV_STAGES];
   logic [31:0]     rem_in  [DIV_STAGES];
   logic [31:0]     den_in  [DIV_STAGES];
   side_type        side_in [DIV_STAGES];

   // Restoring division, two quotient bits per stage, most significant first.
   always_comb begin
      logic [47:0] num;
      logic [47:0] quo;
      logic [31:0] rem;
      logic [31:0] den;
      logic [32:0] rem_sh;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            num = in_num;
            quo = '0;
            rem = '0;
            den = in_den;
            vld_in[j] = in_vld;
            side_in[j] = in_side;
         end else begin
            num = num_ff[j-1];
            quo = quo_ff[j-1];
            rem = rem_ff[j-1];
            den = den_ff[j-1];
            vld_in[j] = vld_ff[j-1];
            side_in[j] = side_ff[j-1];
         end
         for (int k = 0; k < 2; k++) begin
            rem_sh = {rem, num[47]};
            if (rem_sh >= {1'b0, den}) begin
               rem = 32'(rem_sh - {1'b0, den});
               quo = {quo[46:0], 1'b1};
            end else begin
               rem = rem_sh[31:0];
               quo = {quo[46:0], 1'b0};
            end
            num = {num[46:0], 1'b0};
         end
         num_in[j] = num;
         quo_in[j] = quo;
         rem_in[j] = rem;
         den_in[j] = den;
      end
   end

   // Stage registers; only the valid bits need a reset.
   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_in[j];
         end
         num_ff[j] <= num_in[j];
         quo_ff[j] <= quo_in[j];
         rem_ff[j] <= rem_in[j];
         den_ff[j] <= den_in[j];
         side_ff[j] <= side_in[j];
      end
   end

   assign out_vld = vld_ff[DIV_STAGES-1];
   assign out_quo = quo_ff[DIV_STAGES-1];
   assign out_den = den_ff[DIV_STAGES-1];
   assign out_side = side_ff[DIV_STAGES-1];

endmodule

[rtl/core/adagrad_weight_update_core.sv]
// Adagrad weight update core.
// A request word on req_word carries a parameter address, its Q8.24 weight
// and its Q8.24 gradient; req_valid/req_ready move it. Each request yields
// exactly one response word on rsp_word (rsp_valid/rsp_ready), in order:
// the updated, saturated weight, the echoed address and a clip flag.
// The squared-gradient sums live in a PARAM_DEPTH x 64 synchronous RAM that
// is read in stage 2 and written back in the cycle after the read; the
// write of the item just ahead is forwarded when the addresses match.
// An accepted item passes address folding, RAM access and sums, the square
// root pipe, the division pipe and the result queue, in that order.
// Throughput is one word per cycle while req_ready is high; the datapath
// itself never stalls.
// Results land in a 64-word queue. Requests are taken while fewer than 64
// words are in flight or queued, so when the receiver stalls the core keeps
// accepting until that budget is used up, then drops req_ready.
// After reset the core clears the RAM, one entry per cycle, with req_ready
// low until every entry is cleared; csr writes are taken at any time.
// learning_rate resets to 655 and epsilon to 43.
module adagrad_weight_update_core #(
   parameter int PARAM_DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  awu_pkg::req_word_type                  req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output awu_pkg::rsp_word_type                  rsp_word,
   input  logic                                   csr_we,
   input  logic [awu_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [awu_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import awu_pkg::*;

   localparam int IDX_W = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
   localparam logic [31:0] DEPTH_32 = 32'(PARAM_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARAM_DEPTH - 1);
   localparam logic [ACC_W-1:0] ACC_MAX = '1;
   localparam logic signed [49:0] W_MAX = 50'sd2147483647;
   localparam logic signed [49:0] W_MIN = -50'sd2147483648;

   // Configuration registers.
   logic [LR_W-1:0]  lr_ff;
   logic [EPS_W-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= LR_RESET;
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEARNING_RATE: lr_ff <= csr_wdata[LR_W-1:0];
            CSR_EPSILON:       eps_ff <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Clearing sweep after reset.
   logic             clr_busy_ff;
   logic [IDX_W-1:0] clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Credit count: words accepted and not yet taken at the output.
   logic [FIFO_CNT_W-1:0] inflight_ff;
   logic                  req_fire;
   logic                  rsp_fire;
   logic                  rsp_valid_ff;

   assign req_ready = !clr_busy_ff && (inflight_ff < FIFO_CNT_W'(FIFO_DEPTH));
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_ff + FIFO_CNT_W'(req_fire) - FIFO_CNT_W'(rsp_fire);
      end
   end

   // Stage 1: gradient magnitude and the upper half of the address fold.
   logic                     s1_vld_ff;
   logic [ADDR_W-1:0]        s1_addr_ff;
   logic signed [WORD_W-1:0] s1_w_ff;
   logic                     s1_neg_ff;
   logic [WORD_W-1:0]        s1_mag_ff;
   logic [ADDR_W-1:0]        s1_fold_ff;
   logic [ADDR_W-1:0]        s1_fold_in;

   always_comb begin
      logic [ADDR_W-1:0] v;
      v = req_word.param_address;
      for (int k = 11; k >= 6; k--) begin
         if (32'(v) >= (DEPTH_32 << k)) begin
            v = v - ADDR_W'(DEPTH_32 << k);
         end
      end
      s1_fold_in = v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_fire;
      end
      s1_addr_ff <= req_word.param_address;
      s1_w_ff <= req_word.current_weight;
      s1_neg_ff <= req_word.gradient[WORD_W-1];
      s1_mag_ff <= req_word.gradient[WORD_W-1] ? WORD_W'(-req_word.gradient)
                                               : WORD_W'(req_word.gradient);
      s1_fold_ff <= s1_fold_in;
   end

   // Stage 2: finish the fold, square the gradient, read the accumulator.
   logic [ADDR_W-1:0] s2_fold;
   logic [IDX_W-1:0]  s2_idx_in;
   logic [63:0]       sq_prod;

   always_comb begin
      logic [ADDR_W-1:0] v;
      v = s1_fold_ff;
      for (int k = 5; k >= 0; k--) begin
         if (32'(v) >= (DEPTH_32 << k)) begin
            v = v - ADDR_W'(DEPTH_32 << k);
         end
      end
      s2_fold = v;
   end

   assign s2_idx_in = IDX_W'(s2_fold);
   assign sq_prod = s1_mag_ff * s1_mag_ff;

   logic                     s2_vld_ff;
   logic [IDX_W-1:0]         s2_idx_ff;
   logic [ADDR_W-1:0]        s2_addr_ff;
   logic signed [WORD_W-1:0] s2_w_ff;
   logic                     s2_neg_ff;
   logic [WORD_W-1:0]        s2_mag_ff;
   logic [47:0]              s2_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_idx_ff <= s2_idx_in;
      s2_addr_ff <= s1_addr_ff;
      s2_w_ff <= s1_w_ff;
      s2_neg_ff <= s1_neg_ff;
      s2_mag_ff <= s1_mag_ff;
      s2_sq_ff <= sq_prod[63:16];
   end

   // Accumulator RAM with one read and one write port.
   logic [ACC_W-1:0] acc_mem [PARAM_DEPTH];
   logic [ACC_W-1:0] rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [ACC_W-1:0] mem_wd;
   logic [ACC_W-1:0] acc_new;

   assign mem_we = clr_busy_ff || s2_vld_ff;
   assign mem_wa = clr_busy_ff ? clr_idx_ff : s2_idx_ff;
   assign mem_wd = clr_busy_ff ? '0 : acc_new;

   always_ff @(posedge clock) begin
      rd_ff <= acc_mem[s2_idx_in];
      if (mem_we) begin
         acc_mem[mem_wa] <= mem_wd;
      end
   end

   // Last write, forwarded to the item right behind it.
   logic             wr_vld_ff;
   logic [IDX_W-1:0] wr_idx_ff;
   logic [ACC_W-1:0] wr_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= s2_vld_ff && !clr_busy_ff;
      end
      wr_idx_ff <= s2_idx_ff;
      wr_data_ff <= acc_new;
   end

   // Saturating accumulate.
   logic [ACC_W-1:0] acc_base;
   logic [ACC_W:0]   acc_sum;
   logic             acc_clip;

   assign acc_base = (wr_vld_ff && (wr_idx_ff == s2_idx_ff)) ? wr_data_ff : rd_ff;
   assign acc_sum = {1'b0, acc_base} + {1'b0, ACC_W'(s2_sq_ff)};
   assign acc_clip = acc_sum[ACC_W];
   assign acc_new = acc_clip ? ACC_MAX : acc_sum[ACC_W-1:0];

   // Stage 3: accumulator value after the update.
   logic                     s3_vld_ff;
   logic [ADDR_W-1:0]        s3_addr_ff;
   logic signed [WORD_W-1:0] s3_w_ff;
   logic                     s3_neg_ff;
   logic [WORD_W-1:0]        s3_mag_ff;
   logic [ACC_W-1:0]         s3_acc_ff;
   logic                     s3_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_addr_ff <= s2_addr_ff;
      s3_w_ff <= s2_w_ff;
      s3_neg_ff <= s2_neg_ff;
      s3_mag_ff <= s2_mag_ff;
      s3_acc_ff <= acc_new;
      s3_sat_ff <= acc_clip;
   end

   // Stage 4: add epsilon with saturation, form the scaled step numerator.
   logic [ACC_W:0] rad_sum;
   logic [47:0]    step_num;

   assign rad_sum = {1'b0, s3_acc_ff} + {1'b0, ACC_W'(eps_ff)};
   assign step_num = lr_ff * s3_mag_ff;

   logic        s4_vld_ff;
   logic [63:0] s4_rad_ff;
   logic [47:0] s4_p_ff;
   side_type    s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_rad_ff <= rad_sum[ACC_W] ? ACC_MAX : rad_sum[ACC_W-1:0];
      s4_p_ff <= step_num;
      s4_side_ff.addr <= s3_addr_ff;
      s4_side_ff.weight <= s3_w_ff;
      s4_side_ff.neg <= s3_neg_ff;
      s4_side_ff.sat <= s3_sat_ff || rad_sum[ACC_W];
      s4_side_ff.p_nz <= (step_num != '0);
   end

   // Square root, then the division.
   logic        sq_vld;
   logic [31:0] sq_root;
   logic [47:0] sq_p;
   side_type    sq_side;

   awu_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s4_vld_ff),
      .in_x     (s4_rad_ff),
      .in_p     (s4_p_ff),
      .in_side  (s4_side_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_p    (sq_p),
      .out_side (sq_side)
   );

   logic        dv_vld;
   logic [47:0] dv_quo;
   logic [31:0] dv_den;
   side_type    dv_side;

   awu_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (sq_vld),
      .in_num   (sq_p),
      .in_den   (sq_root),
      .in_side  (sq_side),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_den  (dv_den),
      .out_side (dv_side)
   );

   // Apply the step and clip to the Q8.24 range.
   rsp_word_type res_word;

   always_comb begin
      logic signed [49:0] w_ext;
      logic signed [49:0] d_ext;
      logic signed [49:0] nw;
      w_ext = 50'(dv_side.weight);
      d_ext = (dv_den == '0) ? '0 : signed'({2'b00, dv_quo});
      nw = dv_side.neg ? (w_ext + d_ext) : (w_ext - d_ext);
      res_word.out_address = dv_side.addr;
      res_word.saturated = dv_side.sat;
      if ((dv_den == '0) && dv_side.p_nz) begin
         res_word.new_weight = dv_side.neg ? WORD_W'(W_MAX) : WORD_W'(W_MIN);
         res_word.saturated = 1'b1;
      end else if (nw > W_MAX) begin
         res_word.new_weight = WORD_W'(W_MAX);
         res_word.saturated = 1'b1;
      end else if (nw < W_MIN) begin
         res_word.new_weight = WORD_W'(W_MIN);
         res_word.saturated = 1'b1;
      end else begin
         res_word.new_weight = WORD_W'(nw);
      end
   end

   // Result queue; its read data register is the output register.
   rsp_word_type          fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wptr_ff;
   logic [FIFO_PTR_W-1:0] rptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff;
   rsp_word_type          rsp_word_ff;
   logic                  fifo_push;
   logic                  fifo_pop;

   assign fifo_push = dv_vld;
   assign fifo_pop = (fifo_cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem[wptr_ff] <= res_word;
      end
      if (fifo_pop) begin
         rsp_word_ff <= fifo_mem[rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fifo_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fifo_push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (fifo_pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CNT_W'(fifo_push) - FIFO_CNT_W'(fifo_pop);
         if (fifo_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

`ifndef ASSERT_OFF
   // The credit budget keeps the queue from overflowing.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue over capacity");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_cnt_ff != FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("push into full result queue");

   // No pipeline write may collide with the clearing sweep.
   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> !clr_busy_ff)
      else $error("accumulator update during clearing");

   // A visible response always has a credit behind it.
   a_rsp_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (inflight_ff != '0))
      else $error("response without outstanding request");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import awu_pkg::*;

   localparam int DEPTH = 4096;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Idle rates in percent and the long receiver hold-off.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;
   longint cycle_count = 0;

   // Predicts each update and keeps the expected words in order.
   class update_scoreboard;
      logic [63:0] sq_sum [DEPTH];
      logic [15:0] lr;
      logic [31:0] eps;
      rsp_word_type pending_words[$];
      int mismatches = 0;

      function new();
         foreach (sq_sum[i]) sq_sum[i] = 64'd0;
         lr = LR_RESET;
         eps = EPS_RESET;
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] x);
         logic [63:0] res;
         logic [63:0] bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function void note_request(req_word_type w);
         logic [63:0] mag, sq, acc, s, r, p, dmag;
         logic [64:0] wide;
         longint nw, delta;
         bit neg, sat;
         int idx;
         rsp_word_type e;
         neg = w.gradient[31];
         mag = neg ? 64'(-$signed({{32{1'b1}}, w.gradient})) : 64'(w.gradient);
         mag = mag & 64'hFFFF_FFFF;
         idx = int'(w.param_address) % DEPTH;
         sat = 1'b0;
         sq = (mag * mag) >> 16;
         wide = {1'b0, sq_sum[idx]} + {1'b0, sq};
         acc = wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
         if (wide[64]) sat = 1'b1;
         sq_sum[idx] = acc;
         wide = {1'b0, acc} + {33'd0, eps};
         s = wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
         if (wide[64]) sat = 1'b1;
         r = int_sqrt(s);
         p = {48'd0, lr} * mag;
         if (r == 0 && p != 0) begin
            nw = neg ? 64'sd2147483647 : -64'sd2147483648;
            sat = 1'b1;
         end else begin
            dmag = (r == 0) ? 64'd0 : p / r;
            delta = neg ? -$signed(dmag) : $signed(dmag);
            nw = longint'(w.current_weight) - delta;
            if (nw > 64'sd2147483647) begin
               nw = 64'sd2147483647;
               sat = 1'b1;
            end else if (nw < -64'sd2147483648) begin
               nw = -64'sd2147483648;
               sat = 1'b1;
            end
         end
         e.new_weight = nw[31:0];
         e.out_address = w.param_address;
         e.saturated = sat;
         pending_words.push_back(e);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type e;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word %h", got);
            return;
         end
         e = pending_words.pop_front();
         if (got.new_weight !== e.new_weight || got.out_address !== e.out_address ||
             got.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected w=%h a=%h s=%b, got w=%h a=%h s=%b",
                        e.new_weight, e.out_address, e.saturated,
                        got.new_weight, got.out_address, got.saturated);
         end
      endfunction
   endclass

   update_scoreboard board = new();

   adagrad_weight_update_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Count cycles and end the run on a timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** adagrad_weight_update_core: FAILED **");
         $finish;
      end
   end

   // Sample both handshakes at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_word);
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_word);
   end

   // Receiver: random stalls, or a long hold-off when asked.
   always @(negedge clock) begin
      if (recv_hold) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Offer one word and wait until it is taken. Valid stays high after the
   // handshake until the next call idles or offers a new word, or drain drops it.
   task automatic send_word(req_word_type w);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_word <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LEARNING_RATE) board.lr = val[15:0];
      else board.eps = val;
      @(negedge clock);
   endtask

   // Stop offering and wait until all expected words have come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_words.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   function automatic req_word_type make_word(logic [11:0] a, logic [31:0] w,
                                              logic [31:0] g);
      req_word_type r;
      r.param_address = a;
      r.current_weight = w;
      r.gradient = g;
      return r;
   endfunction

   // Gradients mostly small, sometimes full range.
   function automatic logic [31:0] rand_gradient();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(65535)) - 32768);
         default: return 32'($signed($urandom_range(33554431)) - 16777216);
      endcase
   endfunction

   task automatic random_burst(int count, int addr_span);
      for (int i = 0; i < count; i++)
         send_word(make_word(12'($urandom_range(addr_span)), $urandom, rand_gradient()));
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes and saturating weights.
      send_word(make_word(12'd0, 32'h0, 32'h0));
      send_word(make_word(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000));
      send_word(make_word(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF));
      for (int i = 0; i < 8; i++)
         send_word(make_word(12'd7, 32'h8000_0000, 32'h8000_0000));
      send_word(make_word(12'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_word(12'd2, 32'h0100_0000, 32'h0000_0001));
      drain();
      // Epsilon zero with zero gradient gives a zero root.
      write_csr(CSR_EPSILON, 32'd0);
      write_csr(CSR_LEARNING_RATE, 16'hFFFF);
      send_word(make_word(12'd100, 32'h1234_5678, 32'h0));
      send_word(make_word(12'd101, 32'h8000_0000, 32'h1));
      send_word(make_word(12'd4095, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      drain();
      write_csr(CSR_EPSILON, 32'hFFFF_FFFF);
      write_csr(CSR_LEARNING_RATE, 16'd0);
      send_word(make_word(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF));
      send_word(make_word(12'd3, 32'h7FFF_FFFF, 32'h8000_0000));
      drain();

      // Random phases with different settings and idle patterns.
      write_csr(CSR_LEARNING_RATE, LR_RESET);
      write_csr(CSR_EPSILON, EPS_RESET);
      send_idle_pct = 6;
      recv_idle_pct = 84;
      random_burst(300, 31);
      drain();
      write_csr(CSR_LEARNING_RATE, 16'($urandom));
      write_csr(CSR_EPSILON, $urandom);
      send_idle_pct = 84;
      recv_idle_pct = 6;
      random_burst(150, 4095);
      drain();
      write_csr(CSR_LEARNING_RATE, 16'hFFFF);
      write_csr(CSR_EPSILON, 32'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // Long receiver hold-off so the core fills and stalls its input.
      fork
         begin
            recv_hold = 1'b1;
            repeat (300) @(negedge clock);
            recv_hold = 1'b0;
         end
         random_burst(200, 63);
      join
      random_burst(350, 4095);
      drain();

      if (board.mismatches == 0)
         $display("** adagrad_weight_update_core: PASSED **");
      else
         $display("** adagrad_weight_update_core: FAILED **");
      $finish;
   end
endmodule

[filelist.f]
rtl/core/awu_pkg.sv
rtl/core/awu_sqrt_pipe.sv
rtl/core/awu_div_pipe.sv
rtl/core/adagrad_weight_update_core.sv
bench/tb_top.sv
